// ===== src/vt4_pkg.sv =====
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and constants for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int NUM_ROWS        = 4;
  localparam int NUM_COLS        = 4;
  localparam int REG_WIDTH       = 64;
  localparam int ROW_SEL_WIDTH   = 2;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_WIDTH  = 2;
  localparam int FIFO_CNT_WIDTH  = 3;

  typedef logic [REG_WIDTH-1:0]       coef_row_t;
  typedef logic [FIFO_CNT_WIDTH-1:0]  fifo_cnt_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3
  } reg_index_t;

  // Identity matrix in Q8.8 packing
  localparam coef_row_t ROW_RESET [NUM_ROWS] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

endpackage

// ===== src/vt4_in_if.sv =====
// ----------------------------------------------------------------------------
// vt4_in_if
// Vertex channel: valid/ready handshake with four signed components.
// ----------------------------------------------------------------------------
interface vt4_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] in_x;
  logic signed [DATA_WIDTH-1:0] in_y;
  logic signed [DATA_WIDTH-1:0] in_z;
  logic signed [DATA_WIDTH-1:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

// ===== src/vt4_out_if.sv =====
// ----------------------------------------------------------------------------
// vt4_out_if
// Result channel: valid/ready handshake with four components and a flag.
// ----------------------------------------------------------------------------
interface vt4_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic signed [DATA_WIDTH-1:0] out_w;
  logic                         saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

// ===== src/vt4_lane.sv =====
// ----------------------------------------------------------------------------
// vt4_lane
// One matrix row: four registered products, then sum, floor shift and
// saturation into a registered component.
// ----------------------------------------------------------------------------
module vt4_lane
  import vt4_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  coef_row_t                    coefs,
  input  logic signed [DATA_WIDTH-1:0] vec [NUM_COLS],
  output logic signed [DATA_WIDTH-1:0] res,
  output logic                         sat
);

  localparam int PW = (NUM_COLS * DATA_WIDTH > REG_WIDTH) ? NUM_COLS * DATA_WIDTH : REG_WIDTH;
  localparam int PRODW = 2 * DATA_WIDTH;
  localparam int SW    = PRODW + 2;
  localparam logic signed [SW-1:0] MAXV =
    {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic [PW-1:0]               coef_ext;
  logic signed [PRODW-1:0]     prod [NUM_COLS];
  logic signed [SW-1:0]        sum;
  logic signed [SW-1:0]        shifted;
  logic signed [DATA_WIDTH-1:0] res_next;
  logic                        sat_next;

  // Columns packed past the top of the register read as zero
  assign coef_ext = PW'(coefs);

  for (genvar k = 0; k < NUM_COLS; k++) begin : g_col
    logic signed [DATA_WIDTH-1:0] coef;
    assign coef = signed'(coef_ext[k*DATA_WIDTH +: DATA_WIDTH]);
    always_ff @(posedge clk) begin
      prod[k] <= coef * vec[k];
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]);
    // Arithmetic shift gives floor toward minus infinity
    shifted = sum >>> FRAC_BITS;
    if (shifted > MAXV) begin
      res_next = MAXV[DATA_WIDTH-1:0];
      sat_next = 1'b1;
    end else if (shifted < MINV) begin
      res_next = MINV[DATA_WIDTH-1:0];
      sat_next = 1'b1;
    end else begin
      res_next = shifted[DATA_WIDTH-1:0];
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    sat <= sat_next;
  end

endmodule

// ===== src/vt4_merge.sv =====
// ----------------------------------------------------------------------------
// vt4_merge
// Combine the four lane results and saturation flags into one item and
// queue it for the result channel.
// ----------------------------------------------------------------------------
module vt4_merge
  import vt4_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic signed [DATA_WIDTH-1:0] lane_res [NUM_ROWS],
  input  logic [NUM_ROWS-1:0]          lane_sat,
  output fifo_cnt_t                    count,
  vt4_out_if.source                    result
);

  localparam int EW = NUM_ROWS * DATA_WIDTH + 1;

  logic [EW-1:0]               mem [FIFO_DEPTH];
  logic [FIFO_PTR_WIDTH-1:0]   wr_ptr;
  logic [FIFO_PTR_WIDTH-1:0]   rd_ptr;
  logic [EW-1:0]               entry_in;
  logic [EW-1:0]               entry_out;
  logic                        pop;

  assign entry_in = {|lane_sat, lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
  assign pop      = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + fifo_cnt_t'(push) - fifo_cnt_t'(pop);
    end
  end

  assign entry_out        = mem[rd_ptr];
  assign result.valid     = (count != '0);
  assign result.out_x     = signed'(entry_out[0*DATA_WIDTH +: DATA_WIDTH]);
  assign result.out_y     = signed'(entry_out[1*DATA_WIDTH +: DATA_WIDTH]);
  assign result.out_z     = signed'(entry_out[2*DATA_WIDTH +: DATA_WIDTH]);
  assign result.out_w     = signed'(entry_out[3*DATA_WIDTH +: DATA_WIDTH]);
  assign result.saturated = entry_out[EW-1];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fifo_cnt_t'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != fifo_cnt_t'(FIFO_DEPTH)))
    else $error("push into full result queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("result queue count lost a push");

endmodule

// ===== src/vertex_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Transform a stream of Q-format homogeneous vertices by a 4x4 matrix.
//
// The vertex channel takes one item (x, y, z, w) per cycle; the result
// channel gives (x, y, z, w) of the matrix times the vertex, each component
// floored to FRAC_BITS and clipped to DATA_WIDTH signed bits, plus a flag
// that is set when any component clipped. Matrix rows are written over the
// plain write port (index 0 to 3, others ignored); the user must write them
// only while no item is in flight, which the block does not enforce.
//
// Four row lanes run side by side: products register first, sum/shift/clip
// registers next, and a four-entry queue holds the finished items. Each
// item passes the lane registers and the queue; throughput is one item per
// cycle. When the receiver stalls the queue fills, and vertex ready drops
// once the queued plus in-flight items reach four; no item is dropped.
// Reset loads the identity matrix and empties the pipeline and queue.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
  import vt4_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  vt4_in_if.sink                     vertex,
  vt4_out_if.source                  result,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [REG_WIDTH-1:0]       wr_data
);

  coef_row_t                    rows [NUM_ROWS];
  logic signed [DATA_WIDTH-1:0] vec  [NUM_COLS];
  logic signed [DATA_WIDTH-1:0] lane_res [NUM_ROWS];
  logic [NUM_ROWS-1:0]          lane_sat;
  logic                         v1;
  logic                         v2;
  logic                         accept;
  fifo_cnt_t                    count;
  fifo_cnt_t                    inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        rows[i] <= ROW_RESET[i];
      end
    end else if (wr_en && wr_index <= REG_ROW3) begin
      rows[wr_index[ROW_SEL_WIDTH-1:0]] <= wr_data;
    end
  end

  // Hold off new items once every queue slot is spoken for
  assign inflight     = count + fifo_cnt_t'(v1) + fifo_cnt_t'(v2);
  assign vertex.ready = (inflight < fifo_cnt_t'(FIFO_DEPTH));
  assign accept       = vertex.valid && vertex.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  assign vec[0] = vertex.in_x;
  assign vec[1] = vertex.in_y;
  assign vec[2] = vertex.in_z;
  assign vec[3] = vertex.in_w;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    vt4_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .coefs (rows[r]),
      .vec   (vec),
      .res   (lane_res[r]),
      .sat   (lane_sat[r])
    );
  end

  vt4_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (v2),
    .lane_res (lane_res),
    .lane_sat (lane_sat),
    .count    (count),
    .result   (result)
  );

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= fifo_cnt_t'(FIFO_DEPTH))
    else $error("more items in flight than queue slots");

  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2)
    else $error("pipeline stage lost an item");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid)
    else $error("waiting result item withdrawn");

endmodule
